// File: rtl/rpr_pkg.sv
// Shared types and constants of the rational polyphase resampler.
package rpr_pkg;

  // Fixed field widths.
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned COEF_W    = 18;
  localparam int unsigned FACTOR_W  = 7;
  localparam int unsigned TAPS_W    = 12;
  localparam int unsigned DELAY_W   = 10;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned SEEN_W    = 24;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned ACC_W     = 48;
  localparam int unsigned PROD_W    = 40;
  localparam int unsigned MUL_A_W   = 34;
  localparam int unsigned MUL_B_W   = 19;
  localparam int unsigned MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_W     = 40;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int unsigned IN_DATA_W = 48;

  localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

  // Command carried with each input transaction.
  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_PUSH    = 2'd1,
    ACT_FLUSH   = 2'd2,
    ACT_RESTART = 2'd3
  } act_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_UP    = 2'd0,
    REG_DOWN  = 2'd1,
    REG_TAPS  = 2'd2,
    REG_DELAY = 2'd3
  } cfg_reg_e;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TGT_MUL,
    ST_TGT_GO,
    ST_TGT_WAIT,
    ST_TGT_CHK,
    ST_LIM_MUL,
    ST_LIM_SAVE,
    ST_LOOP_MUL,
    ST_LOOP_CHK,
    ST_KMAX_GO,
    ST_KMAX_WAIT,
    ST_TAP_CHK,
    ST_TAP_MUL,
    ST_TAP_ACC,
    ST_RESULT,
    ST_POST,
    ST_CAP_GO,
    ST_CAP_WAIT,
    ST_END
  } state_e;

  // Divider request and response.
  typedef struct packed {
    logic                start;
    logic [DIV_W-1:0]    dividend;
    logic [FACTOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_W-1:0]    quotient;
    logic [FACTOR_W-1:0] remainder;
  } div_rsp_t;

endpackage

// File: rtl/rpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rpr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/rpr_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
module rpr_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpr_pkg::div_req_t req_i,
  output rpr_pkg::div_rsp_t rsp_o
);

  logic                                busy_q;
  logic                                done_q;
  logic [rpr_pkg::DIV_CNT_W-1:0]       cnt_q;
  logic [rpr_pkg::DIV_W-1:0]           quo_q;
  logic [rpr_pkg::FACTOR_W-1:0]        rem_q;
  logic [rpr_pkg::FACTOR_W-1:0]        divisor_q;
  logic [rpr_pkg::FACTOR_W:0]          shifted;
  logic                                ge;

  // Shift in the next dividend bit and trial-subtract.
  always_comb begin
    shifted = {rem_q, quo_q[rpr_pkg::DIV_W-1]};
    ge      = (shifted >= {1'b0, divisor_q});
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= rpr_pkg::DIV_CNT_W'(rpr_pkg::DIV_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == rpr_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Quotient and remainder registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q     <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= {quo_q[rpr_pkg::DIV_W-2:0], ge};
      rem_q <= ge ? rpr_pkg::FACTOR_W'(shifted - {1'b0, divisor_q})
                  : shifted[rpr_pkg::FACTOR_W-1:0];
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// File: rtl/rational_polyphase_resampler_core.sv
// Top level of the rational polyphase resampler: sequencer, shared datapath and stores.
//
// Usage: commands arrive on the slave stream (tuser holds the action: load a
// coefficient, push a sample, flush tick, restart). Results leave on the master
// stream with tlast marking the final result of one command and tuser marking the
// flush result that completes the stream. Registers are written on the cfg
// channel, which is always ready; write them only while the block is idle.
// Loads and restarts complete without leaving the idle state. A push or flush that
// yields outputs first computes its limits, then for each full output index does a
// multiply, a divide (kmax = m*Q/P) and a multiply and accumulate per tap of that
// phase, about taps_used/P taps. Flush adds one divide for the total count; hitting
// the per-sample output cap adds one more. The pace is set by the shared
// bit-serial divider and the single shared multiplier. The block takes a new
// command only in its idle state, and accepts it while the last result still
// waits in the output register. A stalled receiver stalls the sequencer at its
// next result. Reset clears the counters and sets the configuration to defaults;
// no clearing pass is needed: only history entries since the last restart are ever read.
module rational_polyphase_resampler_core #(
  parameter int unsigned COEF_DEPTH    = 2048,
  parameter int unsigned HISTORY_DEPTH = 256,
  parameter int unsigned MAX_FACTOR    = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Command stream.
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: coef_index[10:0], coef_value[28:11], sample_in[44:29], zero pad.
  input  logic [rpr_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: action[1:0].
  input  logic [1:0]                     s_axis_tuser_i,
  // Result stream.
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: sample_out[15:0].
  output logic [rpr_pkg::SAMPLE_W-1:0]   m_axis_tdata_o,
  output logic                           m_axis_tlast_o,
  // tuser: stream_done[0].
  output logic                           m_axis_tuser_o,
  // Configuration writes.
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [rpr_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned CAW  = $clog2(COEF_DEPTH);
  localparam int unsigned HAW  = $clog2(HISTORY_DEPTH);
  localparam int unsigned LH_W = $clog2(COEF_DEPTH + 1);
  localparam int unsigned NW   = LH_W + 1;
  localparam int unsigned IW   = $clog2(MAX_FACTOR + 1);
  localparam int unsigned CW   = rpr_pkg::CNT_W;
  localparam int unsigned PW   = rpr_pkg::PROD_W;
  localparam int unsigned FW   = rpr_pkg::FACTOR_W;

  // Configuration registers.
  logic [FW-1:0]                up_q, down_q;
  logic [rpr_pkg::TAPS_W-1:0]   taps_q;
  logic [rpr_pkg::DELAY_W-1:0]  delay_q;

  // Stream state.
  rpr_pkg::state_e              state_q, state_d;
  logic [rpr_pkg::SEEN_W-1:0]   seen_q;
  logic [CW-1:0]                zeros_q, full_idx_q, emitted_q;
  logic                         flushing_q;
  logic [HAW-1:0]               wptr_q, wptr_next;
  logic                         pend_v_q, out_v_q;

  // Working registers of one command.
  logic [CW-1:0]                k_q, target_q, m_q, kk_q, d_q;
  logic [HAW-1:0]               kslot_q;
  logic [PW-1:0]                lim_q, mq_q;
  logic [IW-1:0]                iter_q;
  logic                         flush_run_q;
  logic [NW-1:0]                n_q;
  logic signed [rpr_pkg::ACC_W-1:0]   acc_q;
  logic signed [rpr_pkg::MUL_P_W-1:0] mul_q;
  logic [rpr_pkg::SAMPLE_W-1:0] pend_data_q, out_data_q;
  logic                         pend_done_q, out_done_q, out_last_q;

  // Shared units.
  logic signed [rpr_pkg::MUL_A_W-1:0] mul_a;
  logic signed [rpr_pkg::MUL_B_W-1:0] mul_b;
  rpr_pkg::div_req_t            div_req;
  rpr_pkg::div_rsp_t            div_rsp;

  // Stores.
  logic                         coef_we, hist_we;
  logic [CAW-1:0]               coef_raddr;
  logic [HAW-1:0]               hist_raddr;
  logic [rpr_pkg::SAMPLE_W-1:0] hist_wdata, hist_rdata;
  logic [rpr_pkg::COEF_W-1:0]   coef_rdata;

  // Decoded command fields.
  rpr_pkg::act_e                act;
  logic [10:0]                  in_idx;
  logic [rpr_pkg::COEF_W-1:0]   in_coef;
  logic [rpr_pkg::SAMPLE_W-1:0] in_sample;

  // Derived values.
  logic [FW-1:0]                p_eff, q_eff;
  logic [LH_W-1:0]              lh;
  logic                         in_fire, out_free, push_ok, loop_go, tap_go, cap_go;
  logic                         brk, tgt_more, res_done, out_load;
  logic [HAW:0]                 d_low, hist_diff;
  logic signed [rpr_pkg::ACC_W-1:0] rnd;
  logic signed [rpr_pkg::ACC_W-18:0] rnd_q;
  logic [rpr_pkg::SAMPLE_W-1:0] res_value;

  assign act       = rpr_pkg::act_e'(s_axis_tuser_i);
  assign in_idx    = s_axis_tdata_i[10:0];
  assign in_coef   = s_axis_tdata_i[28:11];
  assign in_sample = s_axis_tdata_i[44:29];

  assign s_axis_tready_o = (state_q == rpr_pkg::ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_done_q;

  // Clamp the register values to their working ranges.
  always_comb begin
    p_eff = (up_q == '0) ? FW'(1) : ((up_q > FW'(MAX_FACTOR)) ? FW'(MAX_FACTOR) : up_q);
    q_eff = (down_q == '0) ? FW'(1)
          : ((down_q > FW'(MAX_FACTOR)) ? FW'(MAX_FACTOR) : down_q);
    if (taps_q == '0) begin
      lh = LH_W'(1);
    end else if (32'(taps_q) > 32'(COEF_DEPTH)) begin
      lh = LH_W'(COEF_DEPTH);
    end else begin
      lh = LH_W'(taps_q);
    end
  end

  // Conditions used by the sequencer.
  always_comb begin
    in_fire   = s_axis_tvalid_i && (state_q == rpr_pkg::ST_IDLE);
    out_free  = !out_v_q || m_axis_tready_i;
    push_ok   = !flushing_q && (seen_q != rpr_pkg::SEEN_MAX);
    loop_go   = (mul_q[PW-1:0] < lim_q) && (iter_q < IW'(MAX_FACTOR));
    brk       = flush_run_q && (emitted_q >= target_q);
    tgt_more  = (emitted_q < target_q);
    tap_go    = (d_q < CW'(HISTORY_DEPTH)) && (n_q < NW'(lh));
    cap_go    = (iter_q >= IW'(MAX_FACTOR)) && (mq_q < lim_q);
    res_done  = flush_run_q && ((emitted_q + 1'b1) >= target_q);
    wptr_next = (wptr_q == HAW'(HISTORY_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    out_load  = pend_v_q && out_free &&
                ((state_q == rpr_pkg::ST_RESULT) || (state_q == rpr_pkg::ST_END));
  end

  // History address of sample k - d, wrapping around the ring.
  always_comb begin
    d_low     = (HAW + 1)'(d_q);
    hist_diff = {1'b0, kslot_q} - d_low;
    if ({1'b0, kslot_q} < d_low) begin
      hist_diff = hist_diff + (HAW + 1)'(HISTORY_DEPTH);
    end
    hist_raddr = hist_diff[HAW-1:0];
    coef_raddr = n_q[CAW-1:0];
  end

  // Round half up to 15 fraction bits and saturate.
  always_comb begin
    rnd   = acc_q + rpr_pkg::ACC_W'(65536);
    rnd_q = rnd[rpr_pkg::ACC_W-1:17];
    if (rnd_q > 32767) begin
      res_value = 16'h7FFF;
    end else if (rnd_q < -32768) begin
      res_value = 16'h8000;
    end else begin
      res_value = rnd_q[rpr_pkg::SAMPLE_W-1:0];
    end
  end

  // Next state, shared unit operands and store writes.
  always_comb begin
    state_d          = state_q;
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    coef_we          = 1'b0;
    hist_we          = 1'b0;
    hist_wdata       = '0;
    case (state_q)
      rpr_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (act)
            rpr_pkg::ACT_LOAD: begin
              coef_we = (32'(in_idx) < 32'(COEF_DEPTH));
            end
            rpr_pkg::ACT_PUSH: begin
              if (push_ok) begin
                hist_we    = 1'b1;
                hist_wdata = in_sample;
                state_d    = (p_eff == q_eff) ? rpr_pkg::ST_END : rpr_pkg::ST_LIM_MUL;
              end
            end
            rpr_pkg::ACT_FLUSH: begin
              state_d = rpr_pkg::ST_TGT_MUL;
            end
            default: ;
          endcase
        end
      end
      rpr_pkg::ST_TGT_MUL: begin
        mul_a   = rpr_pkg::MUL_A_W'(seen_q);
        mul_b   = rpr_pkg::MUL_B_W'(p_eff);
        state_d = rpr_pkg::ST_TGT_GO;
      end
      rpr_pkg::ST_TGT_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_q[PW-1:0] + PW'(q_eff) - 1'b1;
        div_req.divisor  = q_eff;
        state_d          = rpr_pkg::ST_TGT_WAIT;
      end
      rpr_pkg::ST_TGT_WAIT: begin
        if (div_rsp.done) begin
          state_d = rpr_pkg::ST_TGT_CHK;
        end
      end
      rpr_pkg::ST_TGT_CHK: begin
        if (tgt_more) begin
          hist_we = 1'b1;
          state_d = rpr_pkg::ST_LIM_MUL;
        end else begin
          state_d = rpr_pkg::ST_IDLE;
        end
      end
      rpr_pkg::ST_LIM_MUL: begin
        mul_a   = rpr_pkg::MUL_A_W'({1'b0, k_q} + 1'b1);
        mul_b   = rpr_pkg::MUL_B_W'(p_eff);
        state_d = rpr_pkg::ST_LIM_SAVE;
      end
      rpr_pkg::ST_LIM_SAVE: begin
        state_d = rpr_pkg::ST_LOOP_MUL;
      end
      rpr_pkg::ST_LOOP_MUL: begin
        mul_a   = rpr_pkg::MUL_A_W'(m_q);
        mul_b   = rpr_pkg::MUL_B_W'(q_eff);
        state_d = rpr_pkg::ST_LOOP_CHK;
      end
      rpr_pkg::ST_LOOP_CHK: begin
        if (!loop_go) begin
          state_d = rpr_pkg::ST_POST;
        end else if (m_q >= CW'(delay_q)) begin
          state_d = brk ? rpr_pkg::ST_POST : rpr_pkg::ST_KMAX_GO;
        end else begin
          state_d = rpr_pkg::ST_LOOP_MUL;
        end
      end
      rpr_pkg::ST_KMAX_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = mq_q;
        div_req.divisor  = p_eff;
        state_d          = rpr_pkg::ST_KMAX_WAIT;
      end
      rpr_pkg::ST_KMAX_WAIT: begin
        if (div_rsp.done) begin
          state_d = rpr_pkg::ST_TAP_CHK;
        end
      end
      rpr_pkg::ST_TAP_CHK: begin
        state_d = tap_go ? rpr_pkg::ST_TAP_MUL : rpr_pkg::ST_RESULT;
      end
      rpr_pkg::ST_TAP_MUL: begin
        mul_a   = rpr_pkg::MUL_A_W'($signed(hist_rdata));
        mul_b   = rpr_pkg::MUL_B_W'($signed(coef_rdata));
        state_d = rpr_pkg::ST_TAP_ACC;
      end
      rpr_pkg::ST_TAP_ACC: begin
        state_d = (kk_q == '0) ? rpr_pkg::ST_RESULT : rpr_pkg::ST_TAP_CHK;
      end
      rpr_pkg::ST_RESULT: begin
        if (!pend_v_q || out_free) begin
          state_d = rpr_pkg::ST_LOOP_MUL;
        end
      end
      rpr_pkg::ST_POST: begin
        state_d = cap_go ? rpr_pkg::ST_CAP_GO : rpr_pkg::ST_END;
      end
      rpr_pkg::ST_CAP_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = lim_q + PW'(q_eff) - 1'b1;
        div_req.divisor  = q_eff;
        state_d          = rpr_pkg::ST_CAP_WAIT;
      end
      rpr_pkg::ST_CAP_WAIT: begin
        if (div_rsp.done) begin
          state_d = rpr_pkg::ST_END;
        end
      end
      rpr_pkg::ST_END: begin
        if (!pend_v_q || out_free) begin
          state_d = rpr_pkg::ST_IDLE;
        end
      end
      default: state_d = rpr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers and stream control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q       <= FW'(1);
      down_q     <= FW'(1);
      taps_q     <= rpr_pkg::TAPS_W'(1);
      delay_q    <= '0;
      seen_q     <= '0;
      zeros_q    <= '0;
      full_idx_q <= '0;
      emitted_q  <= '0;
      flushing_q <= 1'b0;
      wptr_q     <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (rpr_pkg::cfg_reg_e'(cfg_index_i))
          rpr_pkg::REG_UP:    up_q    <= cfg_data_i[FW-1:0];
          rpr_pkg::REG_DOWN:  down_q  <= cfg_data_i[FW-1:0];
          rpr_pkg::REG_TAPS:  taps_q  <= cfg_data_i;
          rpr_pkg::REG_DELAY: delay_q <= cfg_data_i[rpr_pkg::DELAY_W-1:0];
          default: ;
        endcase
      end
      // The output register is refilled from the staged result or emptied by the receiver.
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (out_v_q && m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        rpr_pkg::ST_IDLE: begin
          if (in_fire) begin
            case (act)
              rpr_pkg::ACT_RESTART: begin
                seen_q     <= '0;
                zeros_q    <= '0;
                full_idx_q <= '0;
                emitted_q  <= '0;
                flushing_q <= 1'b0;
                wptr_q     <= '0;
              end
              rpr_pkg::ACT_PUSH: begin
                if (push_ok) begin
                  seen_q <= seen_q + 1'b1;
                  wptr_q <= wptr_next;
                  if (p_eff == q_eff) begin
                    pend_v_q  <= 1'b1;
                    emitted_q <= emitted_q + 1'b1;
                  end
                end
              end
              rpr_pkg::ACT_FLUSH: flushing_q <= 1'b1;
              default: ;
            endcase
          end
        end
        rpr_pkg::ST_TGT_CHK: begin
          if (tgt_more) begin
            zeros_q <= zeros_q + 1'b1;
            wptr_q  <= wptr_next;
          end
        end
        rpr_pkg::ST_RESULT: begin
          if (!pend_v_q || out_free) begin
            pend_v_q  <= 1'b1;
            emitted_q <= emitted_q + 1'b1;
          end
        end
        rpr_pkg::ST_POST: begin
          if (!cap_go) begin
            full_idx_q <= m_q;
          end
        end
        rpr_pkg::ST_CAP_WAIT: begin
          if (div_rsp.done) begin
            full_idx_q <= div_rsp.quotient[CW-1:0];
          end
        end
        rpr_pkg::ST_END: begin
          if (pend_v_q && out_free) begin
            pend_v_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers, result staging and the shared multiplier.
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    case (state_q)
      rpr_pkg::ST_IDLE: begin
        k_q         <= CW'(seen_q);
        kslot_q     <= wptr_q;
        flush_run_q <= 1'b0;
        pend_data_q <= in_sample;
        pend_done_q <= 1'b0;
      end
      rpr_pkg::ST_TGT_WAIT: begin
        if (div_rsp.done) begin
          target_q <= div_rsp.quotient[CW-1:0];
        end
      end
      rpr_pkg::ST_TGT_CHK: begin
        k_q         <= CW'(seen_q) + zeros_q;
        kslot_q     <= wptr_q;
        flush_run_q <= 1'b1;
      end
      rpr_pkg::ST_LIM_SAVE: begin
        lim_q  <= mul_q[PW-1:0];
        m_q    <= full_idx_q;
        iter_q <= '0;
      end
      rpr_pkg::ST_LOOP_CHK: begin
        mq_q <= mul_q[PW-1:0];
        if (loop_go) begin
          iter_q <= iter_q + 1'b1;
          if (m_q < CW'(delay_q)) begin
            m_q <= m_q + 1'b1;
          end
        end
      end
      rpr_pkg::ST_KMAX_WAIT: begin
        if (div_rsp.done) begin
          kk_q  <= div_rsp.quotient[CW-1:0];
          d_q   <= k_q - div_rsp.quotient[CW-1:0];
          n_q   <= NW'(div_rsp.remainder);
          acc_q <= '0;
        end
      end
      rpr_pkg::ST_TAP_ACC: begin
        acc_q <= acc_q + mul_q[rpr_pkg::ACC_W-1:0];
        kk_q  <= kk_q - 1'b1;
        d_q   <= d_q + 1'b1;
        n_q   <= n_q + NW'(p_eff);
      end
      rpr_pkg::ST_RESULT: begin
        if (!pend_v_q || out_free) begin
          pend_data_q <= res_value;
          pend_done_q <= res_done;
          m_q         <= m_q + 1'b1;
          if (pend_v_q) begin
            out_data_q <= pend_data_q;
            out_done_q <= pend_done_q;
            out_last_q <= 1'b0;
          end
        end
      end
      rpr_pkg::ST_END: begin
        if (pend_v_q && out_free) begin
          out_data_q <= pend_data_q;
          out_done_q <= pend_done_q;
          out_last_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Shared divider.
  rpr_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Coefficient store.
  rpr_ram #(
    .WIDTH (rpr_pkg::COEF_W),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (CAW'(in_idx)),
    .wdata_i (in_coef),
    .raddr_i (coef_raddr),
    .rdata_o (coef_rdata)
  );

  // Sample history ring.
  rpr_ram #(
    .WIDTH (rpr_pkg::SAMPLE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (wptr_q),
    .wdata_i (hist_wdata),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // A full output register is never overwritten by a new result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rpr_pkg::ST_END && pend_v_q && !out_free) |=> out_v_q)
    else $error("result lost while output register stalled");

  // No staged result is left behind when a command finishes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rpr_pkg::ST_IDLE) |-> !pend_v_q)
    else $error("pending result left in idle");

  // Taps only read history entries inside the ring window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rpr_pkg::ST_TAP_MUL) |-> (d_q < CW'(HISTORY_DEPTH)))
    else $error("history read outside window");

  // The newest contributing sample never lies beyond the current one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rpr_pkg::ST_KMAX_WAIT && div_rsp.done)
      |-> (div_rsp.quotient[CW-1:0] <= k_q))
    else $error("kmax beyond current sample");

  // The per-sample output cap is never exceeded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rpr_pkg::ST_KMAX_GO) |-> (iter_q <= IW'(MAX_FACTOR)) && (iter_q != '0))
    else $error("output iteration count out of range");

endmodule
